// File: hw/rtl/qpe_pkg.sv
package qpe_pkg;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] LIMIT_RESET = 8'd76;

    localparam logic [7:0] CH_DIGIT0 = 8'h30;
    localparam logic [7:0] CH_UPPERA = 8'h41;

    localparam int unsigned CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BINARY_MODE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LINE_LIMIT  = 1'd1;

    typedef struct packed {
        logic       brk;
        logic       esc;
        logic [7:0] data;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

    function automatic logic is_line_end(input logic [7:0] b);
        return (b == CH_CR) || (b == CH_LF);
    endfunction

    function automatic logic must_escape(input logic [7:0] b, input logic bin);
        logic ctl;
        ctl = (b < CH_SPACE) && (b != CH_TAB) && !is_line_end(b);
        return (bin && ((b == CH_SPACE) || (b == CH_TAB) || is_line_end(b)))
            || ctl || (b == CH_EQ) || (b > CH_TILDE);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10) begin
            c = CH_DIGIT0 + {4'd0, n};
        end else begin
            c = CH_UPPERA + {4'd0, n} - 8'd10;
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/qpe_if.sv
interface qpe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [7:0] next_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output next_byte, output is_last,
                    input ready);
    modport sink   (input valid, input data_byte, input next_byte, input is_last,
                    output ready);
endinterface

interface qpe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_end;

    modport source (output valid, output out_byte, output run_end, input ready);
    modport sink   (input valid, input out_byte, input run_end, output ready);
endinterface

interface qpe_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [qpe_pkg::CFG_ADDR_W-1:0]     addr;
    logic [7:0]                         data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

// File: hw/rtl/qpe_front.sv
module qpe_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    qpe_in_if.sink          i_in,
    qpe_cfg_if.sink         i_cfg,
    input  qpe_pkg::t_q_flags i_flags,
    output logic            o_push,
    output qpe_pkg::t_job   o_job
);

    logic       r_bin;
    logic [7:0] r_limit;
    logic [7:0] r_pos;
    logic [7:0] n_pos;

    logic       acc;
    logic       esc;
    logic       brk;
    logic       next_ends;
    logic [8:0] pos_p1;
    logic [8:0] pos_p3;
    logic [7:0] base;
    logic [8:0] sum;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_flags.full;
    assign acc         = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin   <= 1'b0;
            r_limit <= qpe_pkg::LIMIT_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.addr)
                qpe_pkg::CFG_BINARY_MODE: r_bin   <= i_cfg.data[0];
                qpe_pkg::CFG_LINE_LIMIT:  r_limit <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // classify the byte and work out the soft break
    always_comb begin
        esc       = qpe_pkg::must_escape(i_in.data_byte, r_bin);
        next_ends = !i_in.is_last && qpe_pkg::is_line_end(i_in.next_byte);
        pos_p1    = {1'b0, r_pos} + 9'd1;
        pos_p3    = {1'b0, r_pos} + 9'd3;
        if (esc) begin
            brk = (r_limit != 8'd0) && (pos_p3 >= {1'b0, r_limit});
        end else begin
            brk = (r_limit != 8'd0) && (pos_p1 >= {1'b0, r_limit}) && !next_ends;
        end
        base = brk ? 8'd0 : r_pos;
        sum  = {1'b0, base} + (esc ? 9'd3 : 9'd1);
        if (!esc && !r_bin && qpe_pkg::is_line_end(i_in.data_byte)) begin
            n_pos = 8'd0;
        end else begin
            n_pos = sum[8] ? 8'hFF : sum[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 8'd0;
        end else if (acc) begin
            r_pos <= n_pos;
        end
    end

    assign o_push     = acc;
    assign o_job.brk  = brk;
    assign o_job.esc  = esc;
    assign o_job.data = i_in.data_byte;

    a_text_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !esc && !r_bin && qpe_pkg::is_line_end(i_in.data_byte)) |=> (r_pos == 8'd0))
        else $error("line position not cleared after line end");

    a_break_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && brk) |=> (r_pos == 8'd3 || r_pos == 8'd1 || r_pos == 8'd0))
        else $error("line position wrong after soft break");

endmodule

// File: hw/rtl/qpe_fifo.sv
module qpe_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  qpe_pkg::t_job     i_entry,
    input  logic              i_pop,
    output qpe_pkg::t_job     o_head,
    output qpe_pkg::t_q_flags o_flags
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    qpe_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_head        = r_mem[r_rptr];
    assign o_flags.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_flags.empty = (r_cnt == '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// File: hw/rtl/qpe_back.sv
module qpe_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  qpe_pkg::t_job     i_head,
    input  qpe_pkg::t_q_flags i_flags,
    output logic              o_pop,
    qpe_out_if.source         o_out
);

    logic [2:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_end;

    logic       load;
    logic       last;
    logic [2:0] len;
    logic [2:0] j;
    logic [7:0] n_byte;

    assign load = !i_flags.empty && (!r_valid || o_out.ready);

    // serialize one queued job, one byte per cycle while the output is not stalled
    always_comb begin
        len  = i_head.brk ? (i_head.esc ? 3'd6 : 3'd4) : (i_head.esc ? 3'd3 : 3'd1);
        last = (r_idx == len - 3'd1);
        j    = i_head.brk ? r_idx - 3'd3 : r_idx;
        if (i_head.brk && r_idx < 3'd3) begin
            case (r_idx)
                3'd0:    n_byte = qpe_pkg::CH_EQ;
                3'd1:    n_byte = qpe_pkg::CH_CR;
                default: n_byte = qpe_pkg::CH_LF;
            endcase
        end else if (i_head.esc) begin
            case (j)
                3'd0:    n_byte = qpe_pkg::CH_EQ;
                3'd1:    n_byte = qpe_pkg::hex_char(i_head.data[7:4]);
                default: n_byte = qpe_pkg::hex_char(i_head.data[3:0]);
            endcase
        end else begin
            n_byte = i_head.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= last ? 3'd0 : r_idx + 3'd1;
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= n_byte;
            r_end  <= last;
        end
    end

    assign o_pop          = load && last;
    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.run_end  = r_end;

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= 3'd5)
        else $error("byte index out of range");

    a_end_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_valid && r_end))
        else $error("run end not flagged on last byte");

endmodule

// File: hw/rtl/quoted_printable_encoder_top.sv
// an accepted input byte is written to the job queue, then its output bytes pass through the output register
// throughput: one output byte per cycle from the single output register while the output is not stalled
// an input byte yields 1, 3, 4 or 6 output bytes (literal, escape, each with optional soft break)
// a small job queue lets input transactions continue while output is stalled, until the queue is full
// synchronous active-low reset clears line position, queue and output valid, and sets config to text mode, limit 76
module quoted_printable_encoder_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    qpe_in_if.sink  i_in,
    qpe_cfg_if.sink i_cfg,
    qpe_out_if.source o_out
);

    logic              push;
    logic              pop;
    qpe_pkg::t_job     job;
    qpe_pkg::t_job     head;
    qpe_pkg::t_q_flags flags;

    qpe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_flags (flags),
        .o_push  (push),
        .o_job   (job)
    );

    qpe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_flags (flags)
    );

    qpe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_flags (flags),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
